// ===== hdl/ssps_pkg.sv =====
package ssps_pkg;

	localparam int ANGLE_FRAC_BITS = 6;
	localparam int EMA_FRAC_BITS   = 8;

	// shared multiplier operand widths
	localparam int MUL_A_W = 27;
	localparam int MUL_B_W = 25;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// angles in 1/64 degree
	localparam logic [14:0] DEG90  = 15'(90 << ANGLE_FRAC_BITS);
	localparam logic [14:0] DEG180 = 15'(180 << ANGLE_FRAC_BITS);
	localparam logic [14:0] DEG360 = 15'(360 << ANGLE_FRAC_BITS);

	localparam logic [14:0] PULSE_LO_FLOOR = 15'd200;
	localparam logic [14:0] PULSE_LO_CEIL  = 15'd29990;
	localparam logic [14:0] PULSE_HI_CEIL  = 15'd30000;
	localparam logic [14:0] PULSE_GAP      = 15'd10;
	localparam logic [9:0]  SPEED_MAX      = 10'd1000;
	localparam logic [8:0]  ALPHA_ONE      = 9'd256;
	localparam logic [14:0] TOL_FLOOR      = 15'd6;

	// half of 180 degrees for round half up of the angle scaling
	localparam logic [29:0] ANG_ROUND = 30'd5760;

	// floor(2^32 / d) reciprocals for the constant divisions
	localparam int          RECIP_SHIFT = 32;
	localparam logic [26:0] RECIP_125   = 27'd34359738;
	localparam logic [26:0] RECIP_45    = 27'd95443717;
	localparam logic [24:0] DIV_125     = 25'd125;
	localparam logic [24:0] DIV_45      = 25'd45;

	// opcodes
	localparam logic [1:0] OP_TICK       = 2'd0;
	localparam logic [1:0] OP_SET_TARGET = 2'd1;
	localparam logic [1:0] OP_WRITE_DEG  = 2'd2;
	localparam logic [1:0] OP_WRITE_US   = 2'd3;

	// configuration register indexes
	localparam logic [2:0] CFG_PULSE_MIN = 3'd0;
	localparam logic [2:0] CFG_PULSE_MAX = 3'd1;
	localparam logic [2:0] CFG_SPEED     = 3'd2;
	localparam logic [2:0] CFG_ALPHA     = 3'd3;
	localparam logic [2:0] CFG_TOL       = 3'd4;

	// reset values
	localparam logic [14:0] RST_PULSE_MIN = 15'd800;
	localparam logic [14:0] RST_PULSE_MAX = 15'd2200;
	localparam logic [9:0]  RST_SPEED     = 10'd120;
	localparam logic [8:0]  RST_ALPHA     = 9'd90;
	localparam logic [14:0] RST_TOL       = 15'd6;
	localparam logic [22:0] RST_SMOOTH    = 23'(1500 << EMA_FRAC_BITS);

endpackage

// ===== hdl/ssps_cmd_if.sv =====
interface ssps_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [15:0] operand_value;
	logic [15:0] elapsed_ms;

	modport source (output valid, output opcode, output operand_value, output elapsed_ms,
		input ready);
	modport sink (input valid, input opcode, input operand_value, input elapsed_ms,
		output ready);
endinterface

// ===== hdl/ssps_rsp_if.sv =====
interface ssps_rsp_if;
	logic        valid;
	logic        ready;
	logic [14:0] pulse_width_us;
	logic [14:0] current_angle;
	logic        busy_res;

	modport source (output valid, output pulse_width_us, output current_angle,
		output busy_res, input ready);
	modport sink (input valid, input pulse_width_us, input current_angle, input busy_res,
		output ready);
endinterface

// ===== hdl/ssps_mul.sv =====
module ssps_mul
	import ssps_pkg::*;
(
	input  logic               clk,
	input  logic [MUL_A_W-1:0] a,
	input  logic [MUL_B_W-1:0] b,
	output logic [MUL_P_W-1:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= MUL_P_W'(a) * MUL_P_W'(b);
	end

endmodule

// ===== hdl/servo_slew_limited_pulse_smoother_core.sv =====
// Servo pulse generator with slew-rate limit and exponential smoothing. Commands arrive on cmd
// and each one except a tick with zero elapsed time returns one transaction on rsp carrying the
// rounded smoothed pulse width, the present angle and the busy flag. All products and constant
// divisions go through one registered 27x25 multiplier under a small sequencer; a division by a
// constant runs through reciprocal multiply, back multiply and correction. A finished result
// waits in the output register while the next command is accepted; the block stalls only when
// a second result is ready before the first one is taken. The user writes configuration through
// cfg_we/cfg_idx/cfg_wdata while idle; the block itself does not enforce this.
module servo_slew_limited_pulse_smoother_core
	import ssps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [14:0] cfg_wdata,
	ssps_cmd_if.sink    cmd,
	ssps_rsp_if.source  rsp
);

	typedef enum logic [3:0] {
		S_IDLE, S_STEP0, S_DRECIP, S_DBACK, S_DFIX, S_SPAN, S_ANG,
		S_EMA1, S_EMA2, S_EMA3, S_OUT
	} state_t;

	state_t st_q;

	logic [14:0] pmin_q, pmax_q, tol_q;
	logic [9:0]  spd_q;
	logic [8:0]  alpha_q;

	logic [13:0] target_q;
	logic [14:0] present_q;
	logic [22:0] smooth_q;

	logic [13:0] ang_q;
	logic [15:0] us_q;
	logic [24:0] dvd_q;
	logic        sel125_q;
	logic [19:0] q0_q;
	logic [30:0] acc_q;

	logic        out_valid_q;
	logic [14:0] out_pulse_q;
	logic [14:0] out_angle_q;
	logic        out_busy_q;

	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] prod_q;

	// effective limits
	logic [14:0] lo, lo_gap, hi0, hi, span;
	logic [9:0]  spd_c;
	logic [8:0]  alpha_c, alpha_inv;
	logic [14:0] tol_c;

	logic        accept;
	logic [13:0] ang_in;
	logic [14:0] usc;
	logic [21:0] zc;
	logic [24:0] div_d, fix_r;
	logic [19:0] fix_q;
	logic        up;
	logic [14:0] err, step_c, new_p;
	logic [13:0] ang_new;
	logic [29:0] ang_sum;
	logic [31:0] ema_sum;
	logic [23:0] pulse_sum;
	logic        busy_now;

	always_comb begin
		lo        = (pmin_q < PULSE_LO_FLOOR) ? PULSE_LO_FLOOR :
		            ((pmin_q > PULSE_LO_CEIL) ? PULSE_LO_CEIL : pmin_q);
		lo_gap    = lo + PULSE_GAP;
		hi0       = (pmax_q > PULSE_HI_CEIL) ? PULSE_HI_CEIL : pmax_q;
		hi        = (hi0 <= lo_gap) ? lo_gap : hi0;
		span      = hi - lo;
		spd_c     = (spd_q == '0) ? 10'd1 : ((spd_q > SPEED_MAX) ? SPEED_MAX : spd_q);
		alpha_c   = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
		alpha_inv = ALPHA_ONE - alpha_c;
		tol_c     = (tol_q < TOL_FLOOR) ? TOL_FLOOR : tol_q;
	end

	assign accept = cmd.valid && cmd.ready;

	always_comb begin
		ang_in = (cmd.operand_value > {1'b0, DEG180}) ? DEG180[13:0] : cmd.operand_value[13:0];

		if (us_q < {1'b0, lo}) begin
			usc = lo;
		end else if (us_q > {1'b0, hi}) begin
			usc = hi;
		end else begin
			usc = us_q[14:0];
		end

		zc = (|prod_q[25:22]) ? 22'h3FFFFF : prod_q[21:0];

		div_d = sel125_q ? DIV_125 : DIV_45;
		fix_r = dvd_q - prod_q[24:0];
		fix_q = (fix_r >= div_d) ? q0_q + 20'd1 : q0_q;

		up      = {1'b0, target_q} > present_q;
		err     = up ? ({1'b0, target_q} - present_q) : (present_q - {1'b0, target_q});
		step_c  = (fix_q < {5'b0, err}) ? fix_q[14:0] : err;
		new_p   = up ? (present_q + step_c) : (present_q - step_c);
		ang_new = (new_p > DEG180) ? DEG180[13:0] : new_p[13:0];

		ang_sum   = prod_q[29:0] + ANG_ROUND;
		ema_sum   = {1'b0, acc_q} + {1'b0, prod_q[22:0], 8'd0} + 32'd128;
		pulse_sum = {1'b0, smooth_q} + 24'd128;
		busy_now  = err > tol_c;
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (st_q)
			S_IDLE: begin
				case (cmd.opcode)
					OP_TICK: begin
						mul_a = MUL_A_W'(spd_c);
						mul_b = MUL_B_W'(cmd.elapsed_ms);
					end
					OP_WRITE_DEG: begin
						mul_a = MUL_A_W'(span);
						mul_b = MUL_B_W'(ang_in);
					end
					default: begin
						mul_a = MUL_A_W'(alpha_inv);
						mul_b = MUL_B_W'(smooth_q);
					end
				endcase
			end
			S_DRECIP: begin
				mul_a = sel125_q ? RECIP_125 : RECIP_45;
				mul_b = dvd_q;
			end
			S_DBACK: begin
				mul_a = MUL_A_W'(div_d);
				mul_b = MUL_B_W'(prod_q[MUL_P_W-1:RECIP_SHIFT]);
			end
			S_SPAN: begin
				mul_a = MUL_A_W'(span);
				mul_b = MUL_B_W'(ang_q);
			end
			S_EMA1: begin
				mul_a = MUL_A_W'(alpha_inv);
				mul_b = MUL_B_W'(smooth_q);
			end
			S_EMA2: begin
				mul_a = MUL_A_W'(alpha_c);
				mul_b = MUL_B_W'(usc);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	ssps_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pmin_q  <= RST_PULSE_MIN;
			pmax_q  <= RST_PULSE_MAX;
			spd_q   <= RST_SPEED;
			alpha_q <= RST_ALPHA;
			tol_q   <= RST_TOL;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_PULSE_MIN: pmin_q  <= cfg_wdata;
				CFG_PULSE_MAX: pmax_q  <= cfg_wdata;
				CFG_SPEED:     spd_q   <= cfg_wdata[9:0];
				CFG_ALPHA:     alpha_q <= cfg_wdata[8:0];
				CFG_TOL:       tol_q   <= cfg_wdata;
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			target_q    <= DEG90[13:0];
			present_q   <= DEG90;
			smooth_q    <= RST_SMOOTH;
			ang_q       <= '0;
			us_q        <= '0;
			dvd_q       <= '0;
			sel125_q    <= 1'b0;
			q0_q        <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
			out_pulse_q <= '0;
			out_angle_q <= '0;
			out_busy_q  <= 1'b0;
		end else begin
			if (out_valid_q && rsp.ready && st_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (accept) begin
						case (cmd.opcode)
							OP_TICK: begin
								if (cmd.elapsed_ms != '0) begin
									st_q <= S_STEP0;
								end
							end
							OP_SET_TARGET: begin
								target_q <= ang_in;
								st_q     <= S_OUT;
							end
							OP_WRITE_DEG: begin
								present_q <= (cmd.operand_value > {1'b0, DEG360}) ? DEG360 :
								             cmd.operand_value[14:0];
								st_q      <= S_ANG;
							end
							default: begin
								us_q <= cmd.operand_value;
								st_q <= S_EMA2;
							end
						endcase
					end
				end
				S_STEP0: begin
					dvd_q    <= {zc, 3'b000};
					sel125_q <= 1'b1;
					st_q     <= S_DRECIP;
				end
				S_DRECIP: begin
					st_q <= S_DBACK;
				end
				S_DBACK: begin
					q0_q <= prod_q[MUL_P_W-1:RECIP_SHIFT];
					st_q <= S_DFIX;
				end
				S_DFIX: begin
					if (sel125_q) begin
						present_q <= new_p;
						ang_q     <= ang_new;
						st_q      <= S_SPAN;
					end else begin
						us_q <= 16'(lo + fix_q[14:0]);
						st_q <= S_EMA1;
					end
				end
				S_SPAN: begin
					st_q <= S_ANG;
				end
				S_ANG: begin
					dvd_q    <= 25'(ang_sum[29:8]);
					sel125_q <= 1'b0;
					st_q     <= S_DRECIP;
				end
				S_EMA1: begin
					st_q <= S_EMA2;
				end
				S_EMA2: begin
					acc_q <= prod_q[30:0];
					st_q  <= S_EMA3;
				end
				S_EMA3: begin
					smooth_q <= ema_sum[30:8];
					st_q     <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						out_pulse_q <= pulse_sum[22:8];
						out_angle_q <= present_q;
						out_busy_q  <= busy_now;
						st_q        <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cmd.ready          = (st_q == S_IDLE);
	assign rsp.valid          = out_valid_q;
	assign rsp.pulse_width_us = out_pulse_q;
	assign rsp.current_angle  = out_angle_q;
	assign rsp.busy_res       = out_busy_q;

	// zero-time tick gives no result and leaves the block ready
	a_zero_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.opcode == OP_TICK && cmd.elapsed_ms == '0) |=> cmd.ready)
		else $error("zero-time tick did not return to idle");

	a_present_range: assert property (@(posedge clk) disable iff (!arst_n)
		present_q <= DEG360)
		else $error("present angle beyond 360 degrees");

	a_target_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, target_q} <= DEG180)
		else $error("target angle beyond 180 degrees");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(st_q == S_OUT))
		else $error("result loaded outside the output state");

endmodule

// ===== tb/tb_servo_slew_limited_pulse_smoother_core.sv =====
`timescale 1ns / 100ps

module tb_servo_slew_limited_pulse_smoother_core
	import ssps_pkg::*;
;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] operand_value;
		logic [15:0] elapsed_ms;
	} servo_cmd_t;

	typedef struct packed {
		logic [14:0] pulse_width_us;
		logic [14:0] current_angle;
		logic        busy_res;
	} servo_report_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [14:0] cfg_wdata;

	ssps_cmd_if cmd();
	ssps_rsp_if rsp();

	servo_slew_limited_pulse_smoother_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.rsp       (rsp)
	);

	// settings and servo state as the block should hold them
	logic [14:0] pulse_min_cfg;
	logic [14:0] pulse_max_cfg;
	logic [9:0]  speed_cfg;
	logic [8:0]  alpha_cfg;
	logic [14:0] tol_cfg;
	logic [14:0] target_ang;
	logic [14:0] present_ang;
	logic [22:0] smooth_pulse;

	servo_cmd_t    servo_cmds_pending[$];
	servo_report_t pulse_reports_due[$];
	servo_cmd_t    cur_cmd;
	servo_report_t got_report;
	servo_report_t want_report;
	int            fault_count = 0;
	int            burst_left = 0;
	int            gap_left = 0;
	logic [15:0]   stall_pattern = 16'hFFFF;
	int            stall_phase = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [14:0] low_limit();
		logic [14:0] v;
		v = pulse_min_cfg;
		if (v < PULSE_LO_FLOOR) v = PULSE_LO_FLOOR;
		if (v > PULSE_LO_CEIL) v = PULSE_LO_CEIL;
		return v;
	endfunction

	function automatic logic [14:0] high_limit();
		logic [14:0] lo;
		logic [14:0] v;
		lo = low_limit();
		v = pulse_max_cfg;
		if (v > PULSE_HI_CEIL) v = PULSE_HI_CEIL;
		if (v <= lo + PULSE_GAP) v = lo + PULSE_GAP;
		return v;
	endfunction

	function automatic logic [14:0] angle_to_us(logic [15:0] ang);
		longint unsigned span;
		longint unsigned d;
		longint unsigned num;
		span = high_limit() - low_limit();
		d = (ang > DEG180) ? DEG180 : ang;
		num = 2 * span * d + DEG180;
		return 15'(low_limit() + num / (2 * DEG180));
	endfunction

	// clamp to the pulse limits, then one ema step in q8
	function automatic void smooth_toward(logic [15:0] us);
		longint unsigned u;
		longint unsigned a;
		longint unsigned s;
		u = us;
		if (u < low_limit()) u = low_limit();
		if (u > high_limit()) u = high_limit();
		a = (alpha_cfg > ALPHA_ONE) ? ALPHA_ONE : alpha_cfg;
		s = ((ALPHA_ONE - a) * smooth_pulse + a * (u << EMA_FRAC_BITS) + ALPHA_ONE / 2) >> 8;
		smooth_pulse = 23'(s);
	endfunction

	function automatic void apply_servo_cmd(servo_cmd_t c);
		longint unsigned spd;
		longint unsigned step;
		longint unsigned rounded;
		logic [14:0] gap;
		logic [14:0] tol;
		servo_report_t r;
		case (c.opcode)
		OP_TICK: begin
			if (c.elapsed_ms == 16'd0) return;
			spd = speed_cfg;
			if (spd < 1) spd = 1;
			if (spd > SPEED_MAX) spd = SPEED_MAX;
			step = ((spd * c.elapsed_ms) << ANGLE_FRAC_BITS) / 1000;
			if (target_ang > present_ang) begin
				gap = target_ang - present_ang;
				present_ang = present_ang + ((step < gap) ? 15'(step) : gap);
			end else begin
				gap = present_ang - target_ang;
				present_ang = present_ang - ((step < gap) ? 15'(step) : gap);
			end
			smooth_toward({1'b0, angle_to_us({1'b0, present_ang})});
		end
		OP_SET_TARGET: begin
			target_ang = (c.operand_value > DEG180) ? DEG180 : c.operand_value[14:0];
		end
		OP_WRITE_DEG: begin
			rounded = angle_to_us(c.operand_value);
			present_ang = (c.operand_value > DEG360) ? DEG360 : c.operand_value[14:0];
			smooth_toward(16'(rounded));
		end
		default: begin
			smooth_toward(c.operand_value);
		end
		endcase
		tol = (tol_cfg < TOL_FLOOR) ? TOL_FLOOR : tol_cfg;
		gap = (target_ang > present_ang) ? target_ang - present_ang : present_ang - target_ang;
		rounded = (longint'(smooth_pulse) + (1 << (EMA_FRAC_BITS - 1))) >> EMA_FRAC_BITS;
		r.pulse_width_us = 15'(rounded);
		r.current_angle = present_ang;
		r.busy_res = gap > tol;
		pulse_reports_due.push_back(r);
	endfunction

	// command driver: bursts with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd.valid <= 1'b0;
			cmd.opcode <= OP_TICK;
			cmd.operand_value <= 16'd0;
			cmd.elapsed_ms <= 16'd0;
		end else begin
			if (cmd.valid && cmd.ready) apply_servo_cmd(cur_cmd);
			if (!cmd.valid || cmd.ready) begin
				if (gap_left != 0) begin
					gap_left--;
					cmd.valid <= 1'b0;
				end else if (servo_cmds_pending.size() != 0) begin
					cur_cmd = servo_cmds_pending.pop_front();
					cmd.valid <= 1'b1;
					cmd.opcode <= cur_cmd.opcode;
					cmd.operand_value <= cur_cmd.operand_value;
					cmd.elapsed_ms <= cur_cmd.elapsed_ms;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left--;
					end
				end else begin
					cmd.valid <= 1'b0;
				end
			end
		end
	end

	// report monitor with its own stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got_report.pulse_width_us = rsp.pulse_width_us;
				got_report.current_angle = rsp.current_angle;
				got_report.busy_res = rsp.busy_res;
				if (pulse_reports_due.size() == 0) begin
					fault_count++;
					if (fault_count <= 10)
						$display("unexpected transaction: us=%0d angle=%0d busy=%0b",
							got_report.pulse_width_us, got_report.current_angle,
							got_report.busy_res);
				end else begin
					want_report = pulse_reports_due.pop_front();
					if (got_report.pulse_width_us !== want_report.pulse_width_us ||
						got_report.current_angle !== want_report.current_angle ||
						got_report.busy_res !== want_report.busy_res) begin
						fault_count++;
						if (fault_count <= 10)
							$display("mismatch: expected us=%0d angle=%0d busy=%0b, got us=%0d angle=%0d busy=%0b",
								want_report.pulse_width_us, want_report.current_angle,
								want_report.busy_res, got_report.pulse_width_us,
								got_report.current_angle, got_report.busy_res);
					end
				end
			end
			if (stall_phase == 0) begin
				case ($urandom_range(0, 3))
				0: stall_pattern = 16'hFFFF;
				1: stall_pattern = 16'($urandom) | 16'h0001;
				2: stall_pattern = (16'($urandom) & 16'($urandom)) | 16'h8000;
				default: stall_pattern = 16'($urandom) | 16'($urandom) | 16'h0100;
				endcase
				stall_phase = $urandom_range(16, 80);
			end
			stall_phase--;
			rsp.ready <= stall_pattern[stall_phase % 16];
		end
	end

	task automatic queue_cmd(input logic [1:0] op, input logic [15:0] val,
		input logic [15:0] ms);
		servo_cmd_t c;
		c.opcode = op;
		c.operand_value = val;
		c.elapsed_ms = ms;
		servo_cmds_pending.push_back(c);
	endtask

	// half ticks, mostly with short elapsed times, plus target moves, direct writes and noise
	task automatic queue_random_cmds(input int count);
		int made;
		int pick;
		servo_cmd_t c;
		made = 0;
		while (made < count) begin
			c.operand_value = 16'($urandom);
			c.elapsed_ms = 16'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				c.opcode = OP_TICK;
				pick = $urandom_range(0, 99);
				if (pick < 6) c.elapsed_ms = 16'd0;
				else if (pick < 75) c.elapsed_ms = 16'($urandom_range(1, 40));
				else if (pick < 92) c.elapsed_ms = 16'($urandom_range(41, 2000));
			end else if (pick < 68) begin
				c.opcode = OP_SET_TARGET;
				if ($urandom_range(0, 4) != 0)
					c.operand_value = 16'($urandom_range(0, DEG180));
			end else if (pick < 84) begin
				c.opcode = OP_WRITE_DEG;
				pick = $urandom_range(0, 99);
				if (pick < 60) c.operand_value = 16'($urandom_range(0, DEG180));
				else if (pick < 85) c.operand_value = 16'($urandom_range(DEG180, DEG360));
			end else begin
				c.opcode = OP_WRITE_US;
				if ($urandom_range(0, 9) < 7) c.operand_value = 16'($urandom_range(0, 31000));
			end
			servo_cmds_pending.push_back(c);
			if (!(c.opcode == OP_TICK && c.elapsed_ms == 16'd0)) made++;
		end
	endtask

	task automatic set_reg(input logic [2:0] idx, input logic [14:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		case (idx)
		CFG_PULSE_MIN: pulse_min_cfg = data;
		CFG_PULSE_MAX: pulse_max_cfg = data;
		CFG_SPEED:     speed_cfg = data[9:0];
		CFG_ALPHA:     alpha_cfg = data[8:0];
		CFG_TOL:       tol_cfg = data;
		default: ;
		endcase
	endtask

	task automatic load_settings(input logic [14:0] pmin, input logic [14:0] pmax,
		input logic [14:0] spd, input logic [14:0] alpha, input logic [14:0] tol);
		set_reg(CFG_PULSE_MIN, pmin);
		set_reg(CFG_PULSE_MAX, pmax);
		set_reg(CFG_SPEED, spd);
		set_reg(CFG_ALPHA, alpha);
		set_reg(CFG_TOL, tol);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait out all traffic, then the longest command latency
	task automatic drain_block();
		while (servo_cmds_pending.size() != 0 || cmd.valid || pulse_reports_due.size() != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = CFG_PULSE_MIN;
		cfg_wdata = 15'd0;
		cmd.valid = 1'b0;
		cmd.opcode = OP_TICK;
		cmd.operand_value = 16'd0;
		cmd.elapsed_ms = 16'd0;
		rsp.ready = 1'b0;
		pulse_min_cfg = RST_PULSE_MIN;
		pulse_max_cfg = RST_PULSE_MAX;
		speed_cfg = RST_SPEED;
		alpha_cfg = RST_ALPHA;
		tol_cfg = RST_TOL;
		target_ang = DEG90;
		present_ang = DEG90;
		smooth_pulse = RST_SMOOTH;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset settings
		queue_cmd(OP_TICK, 16'hFFFF, 16'd0);
		queue_cmd(OP_TICK, 16'd0, 16'd1);
		queue_cmd(OP_SET_TARGET, 16'd0, 16'hFFFF);
		queue_cmd(OP_TICK, 16'd0, 16'd10);
		queue_cmd(OP_TICK, 16'd0, 16'hFFFF);
		queue_cmd(OP_SET_TARGET, 16'hFFFF, 16'd0);
		queue_cmd(OP_TICK, 16'hFFFF, 16'd1);
		queue_cmd(OP_TICK, 16'd0, 16'd5000);
		queue_cmd(OP_WRITE_DEG, 16'd0, 16'hFFFF);
		queue_cmd(OP_WRITE_DEG, 16'hFFFF, 16'd0);
		queue_cmd(OP_TICK, 16'd0, 16'hFFFF);
		queue_cmd(OP_WRITE_DEG, DEG180, 16'd0);
		queue_cmd(OP_WRITE_DEG, DEG180 + 16'd1, 16'd0);
		queue_cmd(OP_WRITE_DEG, DEG360, 16'd0);
		queue_cmd(OP_SET_TARGET, DEG180 + 16'd1, 16'd0);
		queue_cmd(OP_TICK, 16'd0, 16'd0);
		queue_cmd(OP_TICK, 16'd0, 16'd100);
		queue_cmd(OP_WRITE_US, 16'd0, 16'hFFFF);
		queue_cmd(OP_WRITE_US, 16'hFFFF, 16'd0);
		queue_cmd(OP_WRITE_US, 16'd1500, 16'd0);
		queue_cmd(OP_SET_TARGET, DEG90, 16'd0);
		queue_cmd(OP_TICK, 16'd0, 16'd2);
		queue_cmd(OP_WRITE_DEG, DEG90 + 16'd7, 16'd0);
		queue_cmd(OP_TICK, 16'd0, 16'd1);
		queue_random_cmds(60);
		drain_block();

		load_settings(15'd0, 15'h7FFF, 15'd1000, 15'd256, 15'd0);
		queue_cmd(OP_WRITE_US, 16'd0, 16'd0);
		queue_cmd(OP_WRITE_US, 16'hFFFF, 16'd0);
		queue_random_cmds(70);
		drain_block();

		load_settings(15'h7FFF, 15'd0, 15'd0, 15'd0, 15'h7FFF);
		queue_random_cmds(70);
		drain_block();

		load_settings(15'd500, 15'd2500, 15'd1023, 15'd511, 15'd5);
		queue_random_cmds(70);
		drain_block();

		load_settings(15'd2000, 15'd1000, 15'd1, 15'd1, DEG360);
		queue_random_cmds(70);
		drain_block();

		repeat (3) begin
			load_settings(15'($urandom_range(0, 4000)), 15'($urandom_range(0, 6000)),
				15'($urandom_range(0, 1023)), 15'($urandom_range(0, 300)),
				15'($urandom_range(0, 600)));
			queue_random_cmds(70);
			drain_block();
		end

		if (fault_count == 0 && pulse_reports_due.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/ssps_pkg.sv
hdl/ssps_cmd_if.sv
hdl/ssps_rsp_if.sv
hdl/ssps_mul.sv
hdl/servo_slew_limited_pulse_smoother_core.sv
tb/tb_servo_slew_limited_pulse_smoother_core.sv
